// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge out of reset
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition never holds
`define BPA_NEVER(lbl, cond, msg) \
  `BPA_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Block pool allocator package
// Sizes, field widths, status codes and pointer helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int POOL_BLOCKS     = 1024;
  localparam int OWNERS          = 1024;
  localparam int PER_OWNER_LIMIT = 16;

  localparam int OWNER_W  = 10;
  localparam int QTY_W    = 5;
  localparam int STATUS_W = 3;
  localparam int BLK_W    = 10;
  localparam int FREED_W  = 5;
  localparam int DATA_W   = 16;

  localparam int PTR_W    = $clog2(POOL_BLOCKS);
  localparam int BOR_W    = $clog2(POOL_BLOCKS + 1);
  localparam int OWN_AW   = (OWNERS > 1) ? $clog2(OWNERS) : 1;
  localparam int LIM_W    = $clog2(PER_OWNER_LIMIT + 1);
  localparam int SLOT_W   = (PER_OWNER_LIMIT > 1) ? $clog2(PER_OWNER_LIMIT) : 1;
  localparam int OB_AW    = OWN_AW + SLOT_W;
  localparam int OB_DEPTH = OWNERS * (1 << SLOT_W);
  localparam int SUM_W    = ((BOR_W > QTY_W) ? BOR_W : QTY_W) + 1;
  localparam int CMP_W    = 8;
  localparam int OWN_CMP_W = 17;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_GRANT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADQ  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd4;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(POOL_BLOCKS - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Block pool allocator core
// FIFO free list of block indices with a page table per owner.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser      | tlast
//  in_     | in  | [9:0] owner_id, [14:10] quantity   | kind       | -
//  out_    | out | [9:0] block_index, [14:10] freed   | status     | last
//
//  Allocate of n blocks: one grant per cycle from the free list read port.
//  A refused allocate goes from the check step straight to the reply. Free
//  of n > 0 blocks: one page-table read and one free-list write per cycle;
//  a free of none goes straight to the reply. After reset the owner count
//  table is cleared, one entry a cycle; no request is taken meanwhile.
//  A stalled result register holds the sequencer in its grant or reply step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module block_pool_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bpa_pkg::DATA_W-1:0] in_tdata,   // owner_id, quantity
  input  logic                       in_tuser,   // kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bpa_pkg::DATA_W-1:0] out_tdata,  // block_index, freed_count
  output logic [bpa_pkg::STATUS_W-1:0] out_tuser, // status
  output logic                       out_tlast
);
  import bpa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_GRANT, S_FREE, S_REPLY
  } state_t;

  state_t              state_r, state_nxt;
  logic                kind_r, kind_nxt;
  logic [OWNER_W-1:0]  owner_r, owner_nxt;
  logic [QTY_W-1:0]    qty_r, qty_nxt;
  logic [QTY_W-1:0]    rem_r, rem_nxt;
  logic [LIM_W-1:0]    cnt_r, cnt_nxt;
  logic [LIM_W-1:0]    rd_i_r, rd_i_nxt;
  logic                pend_r, pend_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [BOR_W-1:0]    wrcnt_r, wrcnt_nxt;
  logic [BOR_W-1:0]    borrowed_r, borrowed_nxt;
  logic [OWN_AW-1:0]   clr_idx_r, clr_idx_nxt;
  logic [STATUS_W-1:0] reply_status_r, reply_status_nxt;
  logic [FREED_W-1:0]  reply_freed_r, reply_freed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [BLK_W-1:0]    out_blk_r, out_blk_nxt;
  logic [FREED_W-1:0]  out_freed_r, out_freed_nxt;
  logic                out_last_r, out_last_nxt;

  logic [PTR_W-1:0]    free_list_mem [POOL_BLOCKS];
  logic [PTR_W-1:0]    owner_blocks_mem [OB_DEPTH];
  logic [LIM_W-1:0]    owner_counts_mem [OWNERS];
  logic [PTR_W-1:0]    fl_rd_r;
  logic                fl_hit_r;
  logic [PTR_W-1:0]    ob_rd_r;
  logic [LIM_W-1:0]    oc_rd_r;

  logic                in_acc, slot_free, owner_ok;
  logic                bad_q, pool_short, over_limit;
  logic [OWN_AW-1:0]   owner_idx, in_owner_idx;
  logic [PTR_W-1:0]    blk;
  logic [LIM_W-1:0]    cnt_inc;
  logic                fl_we, ob_we, ob_re, oc_we;
  logic [OB_AW-1:0]    ob_waddr, ob_raddr;
  logic [OWN_AW-1:0]   oc_waddr;
  logic [LIM_W-1:0]    oc_wdata;

  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign slot_free    = !out_valid_r || out_tready;
  assign owner_idx    = OWN_AW'(owner_r);
  assign in_owner_idx = OWN_AW'(in_tdata[OWNER_W-1:0]);
  assign owner_ok     = OWN_CMP_W'(owner_r) < OWN_CMP_W'(OWNERS);
  assign blk          = fl_hit_r ? fl_rd_r : head_r;
  assign cnt_inc      = cnt_r + 1'b1;
  assign bad_q        = !owner_ok || (qty_r == '0)
                        || (CMP_W'(qty_r) > CMP_W'(PER_OWNER_LIMIT));
  assign pool_short   = (SUM_W'(qty_r) + SUM_W'(borrowed_r)) > SUM_W'(POOL_BLOCKS);
  assign over_limit   = (CMP_W'(qty_r) + CMP_W'(oc_rd_r)) > CMP_W'(PER_OWNER_LIMIT);
  assign ob_waddr     = {owner_idx, cnt_r[SLOT_W-1:0]};
  assign ob_raddr     = {owner_idx, rd_i_r[SLOT_W-1:0]};

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_freed_r, out_blk_r};

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    owner_nxt        = owner_r;
    qty_nxt          = qty_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    rd_i_nxt         = rd_i_r;
    pend_nxt         = pend_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    wrcnt_nxt        = wrcnt_r;
    borrowed_nxt     = borrowed_r;
    clr_idx_nxt      = clr_idx_r;
    reply_status_nxt = reply_status_r;
    reply_freed_nxt  = reply_freed_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_status_nxt   = out_status_r;
    out_blk_nxt      = out_blk_r;
    out_freed_nxt    = out_freed_r;
    out_last_nxt     = out_last_r;
    fl_we            = 1'b0;
    ob_we            = 1'b0;
    ob_re            = 1'b0;
    oc_we            = 1'b0;
    oc_waddr         = owner_idx;
    oc_wdata         = '0;

    unique case (state_r)
      S_CLEAR: begin
        oc_we    = 1'b1;
        oc_waddr = clr_idx_r;
        if (clr_idx_r == OWN_AW'(OWNERS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_tuser;
          owner_nxt = in_tdata[OWNER_W-1:0];
          qty_nxt   = in_tdata[OWNER_W+QTY_W-1:OWNER_W];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        reply_freed_nxt = '0;
        if (kind_r == KIND_ALLOC) begin
          priority if (bad_q) begin
            reply_status_nxt = ST_BADQ;
            state_nxt        = S_REPLY;
          end else if (pool_short) begin
            reply_status_nxt = ST_SHORT;
            state_nxt        = S_REPLY;
          end else if (over_limit) begin
            reply_status_nxt = ST_LIMIT;
            state_nxt        = S_REPLY;
          end else begin
            cnt_nxt   = oc_rd_r;
            rem_nxt   = qty_r;
            state_nxt = S_GRANT;
          end
        end else begin
          reply_status_nxt = ST_FREED;
          if (!owner_ok || (oc_rd_r == '0)) begin
            state_nxt = S_REPLY;
          end else begin
            cnt_nxt   = oc_rd_r;
            rd_i_nxt  = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_FREE;
          end
        end
      end
      S_GRANT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_GRANT;
          out_blk_nxt    = BLK_W'(blk);
          out_freed_nxt  = '0;
          out_last_nxt   = (rem_r == QTY_W'(1));
          ob_we          = 1'b1;
          head_nxt       = next_ptr(head_r);
          borrowed_nxt   = borrowed_r + 1'b1;
          cnt_nxt        = cnt_inc;
          rem_nxt        = rem_r - 1'b1;
          if (rem_r == QTY_W'(1)) begin
            oc_we     = 1'b1;
            oc_wdata  = cnt_inc;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FREE: begin
        ob_re    = (rd_i_r < cnt_r);
        pend_nxt = ob_re;
        if (ob_re) begin
          rd_i_nxt = rd_i_r + 1'b1;
        end
        if (pend_r) begin
          fl_we    = 1'b1;
          tail_nxt = next_ptr(tail_r);
          if (wrcnt_r != BOR_W'(POOL_BLOCKS)) begin
            wrcnt_nxt = wrcnt_r + 1'b1;
          end
        end
        if (!ob_re && !pend_r) begin
          borrowed_nxt    = borrowed_r - BOR_W'(cnt_r);
          oc_we           = 1'b1;
          reply_freed_nxt = FREED_W'(cnt_r);
          state_nxt       = S_REPLY;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = reply_status_r;
          out_blk_nxt    = '0;
          out_freed_nxt  = reply_freed_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      wrcnt_r     <= '0;
      borrowed_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_idx_r      <= clr_idx_nxt;
      head_r         <= head_nxt;
      tail_r         <= tail_nxt;
      wrcnt_r        <= wrcnt_nxt;
      borrowed_r     <= borrowed_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
      kind_r         <= kind_nxt;
      owner_r        <= owner_nxt;
      qty_r          <= qty_nxt;
      rem_r          <= rem_nxt;
      cnt_r          <= cnt_nxt;
      rd_i_r         <= rd_i_nxt;
      reply_status_r <= reply_status_nxt;
      reply_freed_r  <= reply_freed_nxt;
      out_status_r   <= out_status_nxt;
      out_blk_r      <= out_blk_nxt;
      out_freed_r    <= out_freed_nxt;
      out_last_r     <= out_last_nxt;
    end
  end

  // read at the next head so the read data always matches head_r
  always_ff @(posedge clk) begin
    if (fl_we) begin
      free_list_mem[tail_r] <= ob_rd_r;
    end
    fl_rd_r  <= free_list_mem[head_nxt];
    fl_hit_r <= (BOR_W'(head_nxt) < wrcnt_r);
  end

  always_ff @(posedge clk) begin
    if (ob_we) begin
      owner_blocks_mem[ob_waddr] <= blk;
    end
    if (ob_re) begin
      ob_rd_r <= owner_blocks_mem[ob_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (oc_we) begin
      owner_counts_mem[oc_waddr] <= oc_wdata;
    end
    if (in_acc) begin
      oc_rd_r <= owner_counts_mem[in_owner_idx];
    end
  end

  `BPA_NEVER(a_borrow_bound, borrowed_r > BOR_W'(POOL_BLOCKS), "borrowed count above pool size")
  `BPA_ASSERT(a_clear_quiet, (state_r == S_CLEAR) |-> (!in_tready && !out_tvalid), "activity during clear pass")
  `BPA_ASSERT(a_idle_ptrs, (state_r == S_IDLE && (borrowed_r == '0 || borrowed_r == BOR_W'(POOL_BLOCKS))) |-> (head_r == tail_r), "free list pointers out of step with borrowed count")

endmodule
